// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on i_clk, gated by reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check of a property on every clock edge outside reset.
`define WFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that an antecedent in one cycle implies a consequent in the next.
`define WFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wft_pkg.sv =====
// ----------------------------------------------------------------------------
// wft_pkg
// Shared constants, types and arithmetic helpers of the Winograd filter
// transform unit.
// ----------------------------------------------------------------------------
package wft_pkg;

    localparam int MAX_CHANNELS = 4096;
    localparam int CFG_W        = 13;
    localparam int CNT_W        = $clog2(MAX_CHANNELS);
    localparam int BLK_W        = CFG_W - 2;
    localparam int W_W          = 16;
    localparam int M_W          = W_W + 2;
    localparam int V_W          = 20;
    localparam int IDX_W        = 28;
    localparam int TAPS         = 9;
    localparam int TAP_W        = $clog2(TAPS);
    localparam int OUTS         = 16;
    localparam int RES_W        = $clog2(OUTS);

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_OUT_CHANNELS = 1'b0;
    localparam t_cfg_idx CFG_IN_CHANNELS  = 1'b1;

    typedef logic signed [M_W-1:0] t_mval;
    typedef t_mval [2:0]           t_mrow;

    // One finished kernel: G*g rows plus image addressing.
    typedef struct packed {
        t_mrow [3:0]      m;
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] stride;
    } t_job;

    // Clamp a channel count register into 1..MAX_CHANNELS.
    function automatic logic [CFG_W-1:0] wft_limit(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > CFG_W'(MAX_CHANNELS)) begin
            r = CFG_W'(MAX_CHANNELS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic t_mval wft_ext(input logic [W_W-1:0] w);
        return t_mval'({{(M_W - W_W){w[W_W-1]}}, w});
    endfunction

    // Element c of one row of K = (G*g)*GT.
    function automatic logic signed [V_W-1:0] wft_kval(input t_mrow row,
                                                       input logic [1:0] col);
        logic signed [V_W-1:0] a;
        logic signed [V_W-1:0] b;
        logic signed [V_W-1:0] d;
        logic signed [V_W-1:0] r;
        a = V_W'(row[0]);
        b = V_W'(row[1]);
        d = V_W'(row[2]);
        case (col)
            2'd0:    r = a;
            2'd1:    r = a + b + d;
            2'd2:    r = a - b + d;
            2'd3:    r = d;
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/wft_front.sv =====
// ----------------------------------------------------------------------------
// wft_front
// Collects nine taps, forms G*g and the image addressing of the kernel,
// and hands a finished kernel to the queue. Holds the channel registers.
// ----------------------------------------------------------------------------
module wft_front import wft_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_accept,
    input  logic [W_W-1:0]   i_weight,
    output logic             o_job_push,
    output t_job             o_job
);

    logic [CFG_W-1:0] r_out_channels;
    logic [CFG_W-1:0] r_in_channels;
    logic [W_W-1:0]   r_taps [TAPS];
    logic [TAP_W-1:0] r_tap_cnt;
    logic [CNT_W-1:0] r_oc;
    logic [CNT_W-1:0] r_ic;

    logic [TAP_W-1:0] n_tap_cnt;
    logic [CNT_W-1:0] n_oc;
    logic [CNT_W-1:0] n_ic;
    logic [CFG_W-1:0] co;
    logic [CFG_W-1:0] ci;
    logic [BLK_W-1:0] co4;
    logic [BLK_W-1:0] ci4;
    logic [CFG_W-1:0] co_sum;
    logic [CFG_W-1:0] ci_sum;
    logic [CFG_W:0]   ic_inc;
    logic [CFG_W:0]   oc_inc;
    logic [W_W-1:0]   g [TAPS];
    logic             ninth;
    logic [2*BLK_W-1:0] blk_prod;
    logic [2*BLK_W-1:0] row_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_channels <= CFG_W'(1);
            r_in_channels  <= CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OUT_CHANNELS: r_out_channels <= i_cfg_data;
                CFG_IN_CHANNELS:  r_in_channels  <= i_cfg_data;
                default:          r_out_channels <= r_out_channels;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_taps[r_tap_cnt] <= i_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_cnt <= '0;
            r_oc      <= '0;
            r_ic      <= '0;
        end else begin
            r_tap_cnt <= n_tap_cnt;
            r_oc      <= n_oc;
            r_ic      <= n_ic;
        end
    end

    always_comb begin
        co     = wft_limit(r_out_channels);
        ci     = wft_limit(r_in_channels);
        co_sum = co + CFG_W'(3);
        ci_sum = ci + CFG_W'(3);
        co4    = co_sum[CFG_W-1:2];
        ci4    = ci_sum[CFG_W-1:2];
        ninth  = i_accept && (r_tap_cnt == TAP_W'(TAPS - 1));

        for (int t = 0; t < TAPS - 1; t++) begin
            g[t] = r_taps[t];
        end
        g[TAPS-1] = i_weight;

        n_tap_cnt = r_tap_cnt;
        n_oc      = r_oc;
        n_ic      = r_ic;
        ic_inc    = {2'b00, r_ic} + (CFG_W + 1)'(1);
        oc_inc    = {2'b00, r_oc} + (CFG_W + 1)'(1);
        if (i_accept) begin
            n_tap_cnt = (ninth || r_tap_cnt >= TAP_W'(TAPS - 1)) ? '0 : r_tap_cnt + 1'b1;
        end
        if (ninth) begin
            // Advance the input channel, carry into the output channel.
            if (ic_inc >= {1'b0, ci}) begin
                n_ic = '0;
                n_oc = (oc_inc >= {1'b0, co}) ? '0 : oc_inc[CNT_W-1:0];
            end else begin
                n_ic = ic_inc[CNT_W-1:0];
            end
        end

        for (int c = 0; c < 3; c++) begin
            o_job.m[0][c] = wft_ext(g[c]);
            o_job.m[1][c] = wft_ext(g[c]) + wft_ext(g[3 + c]) + wft_ext(g[6 + c]);
            o_job.m[2][c] = wft_ext(g[c]) - wft_ext(g[3 + c]) + wft_ext(g[6 + c]);
            o_job.m[3][c] = wft_ext(g[6 + c]);
        end

        blk_prod     = co4 * ci4;
        row_prod     = (2*BLK_W)'(r_oc[CNT_W-1:2]) * (2*BLK_W)'(ci4);
        o_job.stride = IDX_W'({blk_prod, 4'b0000});
        o_job.base   = IDX_W'({row_prod, 4'b0000})
                     + IDX_W'({r_ic[CNT_W-1:2], 4'b0000})
                     + IDX_W'({r_ic[1:0], 2'b00})
                     + IDX_W'(r_oc[1:0]);
        o_job_push   = ninth;
    end

endmodule

// ===== rtl/wft_queue.sv =====
// ----------------------------------------------------------------------------
// wft_queue
// Two-entry queue of finished kernels between the front and the back.
// ----------------------------------------------------------------------------
module wft_queue import wft_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       wr;
    logic       rd;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd_ptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({wr, rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/wft_back.sv =====
// ----------------------------------------------------------------------------
// wft_back
// Walks the sixteen elements of the queue-head kernel into the result register,
// one per cycle unless a result waits unpopped; steps the image index by stride.
// ----------------------------------------------------------------------------
module wft_back import wft_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_job                  i_job,
    input  logic                  i_job_empty,
    output logic                  o_job_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic signed [V_W-1:0] o_value,
    output logic [IDX_W-1:0]      o_image_index,
    output logic                  o_last
);

    logic [RES_W-1:0]      r_res;
    logic [IDX_W-1:0]      r_acc;
    logic                  r_valid;
    logic signed [V_W-1:0] r_value;
    logic [IDX_W-1:0]      r_index;
    logic                  r_last;

    logic                  adv;
    logic                  fire;
    logic [IDX_W-1:0]      idx;

    assign adv       = !r_valid || i_pop;
    assign fire      = adv && !i_job_empty;
    assign o_job_pop = fire && (r_res == RES_W'(OUTS - 1));
    assign idx       = (r_res == '0) ? i_job.base : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_res <= r_res + 1'b1;
            end
            if (adv) begin
                r_valid <= !i_job_empty;
            end
        end
    end

    // Hold the payload while the result waits; load it when a new one fires.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_value <= wft_kval(i_job.m[r_res[3:2]], r_res[1:0]);
            r_index <= idx;
            r_last  <= (r_res == RES_W'(OUTS - 1));
            r_acc   <= idx + i_job.stride;
        end
    end

    assign o_empty       = !r_valid;
    assign o_value       = r_value;
    assign o_image_index = r_index;
    assign o_last        = r_last;

endmodule

// ===== rtl/winograd_filter_transform_unit.sv =====
// With the back end idle, a kernel enters the queue at the edge that takes its ninth
// weight, and its first result is then registered from the queue head onto the ports.
// Throughput: one weight per cycle while o_full is low; the back end drains 16
// results at one per cycle while they are popped, so it paces a steady stream.
// Two finished kernels may wait in the queue; full rises while both are held.
// Reset (i_rst_n low, synchronous) empties the queue and result register,
// clears the tap and channel counters and sets both channel counts to 1.
// ----------------------------------------------------------------------------
// winograd_filter_transform_unit
// Winograd F(2,3) filter transform with 4-channel blocked image indexing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module winograd_filter_transform_unit import wft_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic signed [W_W-1:0] i_weight,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic signed [V_W-1:0] o_value,
    output logic [IDX_W-1:0]      o_image_index,
    output logic                  o_last
);

    logic accept;
    logic job_push;
    t_job job_in;
    t_job job_head;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign o_full = q_full;
    assign accept = i_push && !q_full;

    wft_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_weight    (i_weight),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    wft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (job_head),
        .o_empty (q_empty)
    );

    wft_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (job_head),
        .i_job_empty   (q_empty),
        .o_job_pop     (q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_value       (o_value),
        .o_image_index (o_image_index),
        .o_last        (o_last)
    );

    `WFT_ASSERT(a_no_push_full, !(job_push && q_full), "kernel pushed into full queue")
    `WFT_ASSERT(a_pop_nonempty, !(q_pop && q_empty), "kernel popped from empty queue")
    `WFT_ASSERT_NEXT(a_last_pops, q_pop, !o_empty && o_last, "queue pop without last result")
    `WFT_ASSERT_NEXT(a_result_held, !o_empty && !i_pop, !o_empty, "waiting result dropped")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Winograd filter transform unit. Streams 3x3
// weights through the queue ports under several channel settings and pacing
// patterns, and checks every transformed element, its image index and the
// end-of-kernel flag against a cycle-free predictor of the transform.
// ----------------------------------------------------------------------------
module tb_top;
    import wft_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_CAP      = 40;

    localparam logic signed [W_W-1:0] WMAX = 16'sh7fff;
    localparam logic signed [W_W-1:0] WMIN = 16'sh8000;

    // One directed weight; on the ninth tap of a kernel the first element and
    // its index may be pinned to a hand-computed value.
    typedef struct packed {
        logic signed [W_W-1:0] weight;
        logic                  pin;
        logic signed [V_W-1:0] k00;
        logic [IDX_W-1:0]      idx0;
    } t_tap_row;

    typedef struct {
        logic signed [V_W-1:0] value;
        logic [IDX_W-1:0]      index;
        logic                  last;
    } t_kelem;

    // All-max, all-min and checkerboard kernels at the reset channel counts.
    localparam t_tap_row TAP_TABLE [27] = '{
        '{WMAX, 1'b0, '0, '0}, '{WMAX, 1'b0, '0, '0}, '{WMAX, 1'b0, '0, '0},
        '{WMAX, 1'b0, '0, '0}, '{WMAX, 1'b0, '0, '0}, '{WMAX, 1'b0, '0, '0},
        '{WMAX, 1'b0, '0, '0}, '{WMAX, 1'b0, '0, '0},
        '{WMAX, 1'b1, 20'sd32767, 28'd0},
        '{WMIN, 1'b0, '0, '0}, '{WMIN, 1'b0, '0, '0}, '{WMIN, 1'b0, '0, '0},
        '{WMIN, 1'b0, '0, '0}, '{WMIN, 1'b0, '0, '0}, '{WMIN, 1'b0, '0, '0},
        '{WMIN, 1'b0, '0, '0}, '{WMIN, 1'b0, '0, '0},
        '{WMIN, 1'b1, -20'sd32768, 28'd0},
        '{WMAX, 1'b0, '0, '0}, '{WMIN, 1'b0, '0, '0}, '{WMAX, 1'b0, '0, '0},
        '{WMIN, 1'b0, '0, '0}, '{WMAX, 1'b0, '0, '0}, '{WMIN, 1'b0, '0, '0},
        '{WMAX, 1'b0, '0, '0}, '{WMIN, 1'b0, '0, '0},
        '{WMAX, 1'b1, 20'sd32767, 28'd0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  i_push;
    logic                  o_full;
    logic signed [W_W-1:0] i_weight;
    logic                  i_pop;
    logic                  o_empty;
    logic signed [V_W-1:0] o_value;
    logic [IDX_W-1:0]      o_image_index;
    logic                  o_last;

    // Predictor state
    logic signed [W_W-1:0] taps [TAPS] = '{default: '0};
    int unsigned           tap_cnt = 0;
    int unsigned           oc_cnt = 0;
    int unsigned           ic_cnt = 0;
    logic [CFG_W-1:0]      oc_reg = CFG_W'(1);
    logic [CFG_W-1:0]      ic_reg = CFG_W'(1);
    t_kelem                kernel_elems [$];

    int gap_pct   = 0;
    int stall_pct = 0;
    int err_count = 0;

    winograd_filter_transform_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_weight      (i_weight),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_value       (o_value),
        .o_image_index (o_image_index),
        .o_last        (o_last)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int unsigned chan_limit(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (v > CFG_W'(MAX_CHANNELS)) begin
            return MAX_CHANNELS;
        end
        return 32'(v);
    endfunction

    // Row of G (or column of GT) applied to three values.
    function automatic int wino_g(input int a, input int b, input int c, input int row);
        case (row)
            0:       return a;
            1:       return a + b + c;
            2:       return a - b + c;
            default: return c;
        endcase
    endfunction

    function automatic logic signed [W_W-1:0] rand_weight();
        case ($urandom_range(7))
            0:       return WMAX;
            1:       return WMIN;
            2:       return '0;
            default: return W_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_CAP) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        err_count++;
    endtask

    // Take one weight; on the ninth, queue the sixteen kernel elements.
    task automatic take_weight(input logic signed [W_W-1:0] w);
        int          gcol [4][3];
        int unsigned co4;
        int unsigned ci4;
        int unsigned base;
        int unsigned stride;
        int unsigned n;
        t_kelem      e;
        taps[tap_cnt] = w;
        tap_cnt++;
        if (tap_cnt == TAPS) begin
            tap_cnt = 0;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    gcol[r][c] = wino_g(taps[c], taps[3 + c], taps[6 + c], r);
                end
            end
            co4    = (chan_limit(oc_reg) + 3) / 4;
            ci4    = (chan_limit(ic_reg) + 3) / 4;
            stride = co4 * ci4 * 16;
            base   = (oc_cnt / 4) * ci4 * 16 + (ic_cnt / 4) * 16
                   + (ic_cnt % 4) * 4 + (oc_cnt % 4);
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    n       = r * 4 + c;
                    e.value = V_W'(wino_g(gcol[r][0], gcol[r][1], gcol[r][2], c));
                    e.index = IDX_W'(base + n * stride);
                    e.last  = (n == OUTS - 1);
                    kernel_elems.push_back(e);
                end
            end
            ic_cnt++;
            if (ic_cnt >= chan_limit(ic_reg)) begin
                ic_cnt = 0;
                oc_cnt++;
                if (oc_cnt >= chan_limit(oc_reg)) begin
                    oc_cnt = 0;
                end
            end
        end
    endtask

    task automatic check_result();
        t_kelem e;
        if (kernel_elems.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d index %0d",
                                      o_value, o_image_index));
        end else begin
            e = kernel_elems.pop_front();
            if (o_value !== e.value) begin
                report_mismatch($sformatf("value %0d, expected %0d", o_value, e.value));
            end
            if (o_image_index !== e.index) begin
                report_mismatch($sformatf("image_index %0d, expected %0d",
                                          o_image_index, e.index));
            end
            if (o_last !== e.last) begin
                report_mismatch($sformatf("last %0b, expected %0b", o_last, e.last));
            end
        end
    endtask

    task automatic push_weight(input logic signed [W_W-1:0] w);
        while ($urandom_range(99) < gap_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push   <= 1'b1;
        i_weight <= w;
        do @(posedge i_clk); while (o_full);
        take_weight(w);
    endtask

    // Hold off the sender until every queued element has been popped.
    task automatic drain_results();
        i_push <= 1'b0;
        do @(posedge i_clk); while (kernel_elems.size() != 0);
    endtask

    task automatic set_channels(input logic [CFG_W-1:0] oc, input logic [CFG_W-1:0] ic);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_OUT_CHANNELS;
        i_cfg_data  <= oc;
        @(posedge i_clk);
        oc_reg = oc;
        i_cfg_index <= CFG_IN_CHANNELS;
        i_cfg_data  <= ic;
        @(posedge i_clk);
        ic_reg = ic;
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] oc, input logic [CFG_W-1:0] ic,
                             input int gap, input int stall, input int count,
                             input int pause_at);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        set_channels(oc, ic);
        gap_pct   = gap;
        stall_pct = stall;
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) begin
                drain_results();
            end
            push_weight(rand_weight());
        end
    endtask

    // Result side: pop at random and check each transfer.
    initial begin
        i_pop <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (i_pop && !o_empty) begin
                check_result();
            end
            i_pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_push && !o_full) || (i_pop && !o_empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_OUT_CHANNELS;
        i_cfg_data  <= '0;
        i_push      <= 1'b0;
        i_weight    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (TAP_TABLE[k]) begin
            push_weight(TAP_TABLE[k].weight);
            if (TAP_TABLE[k].pin) begin
                kernel_elems[kernel_elems.size() - OUTS].value = TAP_TABLE[k].k00;
                kernel_elems[kernel_elems.size() - OUTS].index = TAP_TABLE[k].idx0;
            end
        end

        // Zero and oversized counts clamp; later phases shrink the limits
        // mid-tensor so the channel counters wrap from above.
        run_phase(13'd0,    13'd0,    0,  0,  50, -1);
        run_phase(13'd8191, 13'd8191, 79, 0,  50, -1);
        run_phase(13'd5,    13'd3,    0,  79, 55, -1);
        run_phase(13'd6,    13'd7,    8,  8,  50, 25);
        run_phase(13'd2,    13'd2,    0,  0,  50, -1);
        run_phase(13'd4097, 13'd1,    79, 0,  55, -1);
        run_phase(13'd1,    13'd4096, 0,  79, 55, -1);
        run_phase(13'd13,   13'd9,    8,  8,  55, -1);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== winograd_filter_transform_unit.f =====
+incdir+rtl
rtl/wft_pkg.sv
rtl/wft_front.sv
rtl/wft_queue.sv
rtl/wft_back.sv
rtl/winograd_filter_transform_unit.sv
sim/tb_top.sv
